[rtl/core/fcs_pkg.sv]
// shared types and constants for the facet cull and flat shade block
// no dependencies; used by fcs_div, fcs_sqrt and the top level
`default_nettype none

package fcs_pkg;

    // field widths
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 15;
    localparam int LIGHT_BITS = 16;
    localparam int NUM_COORDS = 9;

    // stream packing
    localparam int IN_W      = NUM_COORDS * COORD_BITS;
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = 1 + 16 + 4 + 1;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // arithmetic widths
    localparam int SH      = 15 - FRAC_BITS;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int NRM_W   = 2 * DIFF_W;
    localparam int PROD_W  = NRM_W + LIGHT_BITS;
    localparam int DOT_W   = PROD_W + 2;
    localparam int DOTU_W  = DOT_W - 1;
    localparam int DLO_W   = DOTU_W / 2;
    localparam int DHI_W   = DOTU_W - DLO_W;
    localparam int SQ_W    = 2 * NRM_W - 1;
    localparam int N2_W    = SQ_W + 2;
    localparam int D2_W    = 2 * DOTU_W;
    localparam int R_W     = 2 * FRAC_BITS;
    localparam int QBITS   = R_W + 1;
    localparam int REM_W   = (D2_W > N2_W + 2 * SH + R_W) ? D2_W : N2_W + 2 * SH + R_W;
    localparam int FILL_STEPS = 14;

    // light register reset values
    localparam logic [LIGHT_BITS-1:0] LIGHT_X_RST = 16'd25173;
    localparam logic [LIGHT_BITS-1:0] LIGHT_Y_RST = 16'd16782;
    localparam logic [LIGHT_BITS-1:0] LIGHT_Z_RST = 16'd12587;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic vis;
        logic pos;
    } flags_t;

    typedef struct packed {
        flags_t            flags;
        logic [D2_W-1:0]   d2;
        logic [N2_W-1:0]   n2;
    } div_in_t;

    typedef struct packed {
        flags_t            flags;
        logic              sat;
        logic [R_W-1:0]    ratio;
    } div_out_t;

    typedef struct packed {
        flags_t                flags;
        logic                  sat;
        logic [FRAC_BITS-1:0]  root;
    } sqrt_out_t;

endpackage

`default_nettype wire

[rtl/core/fcs_div.sv]
// pipelined restoring divider: floor(d2 / (n2 << 2*SH)), one quotient bit per stage
// depends on fcs_pkg
`default_nettype none

module fcs_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fcs_pkg::div_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fcs_pkg::div_out_t      out_data
);
    import fcs_pkg::*;

    logic               v_reg    [QBITS];
    logic               en       [QBITS];
    logic [REM_W-1:0]   rem_reg  [QBITS];
    logic [N2_W-1:0]    n2_reg   [QBITS];
    logic [QBITS-1:0]   quo_reg  [QBITS];
    flags_t             flags_reg[QBITS];

    // stall chain: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[QBITS-1] = !v_reg[QBITS-1] || out_ready;
        for (int k = QBITS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    for (genvar k = 0; k < QBITS; k++)
    begin : g_stage
        localparam int BIT = QBITS - 1 - k;
        logic               v_in;
        logic [REM_W-1:0]   rem_in;
        logic [N2_W-1:0]    n2_in;
        logic [QBITS-1:0]   quo_in;
        flags_t             flags_in;
        logic [REM_W-1:0]   dvs;
        logic               take;
        logic [REM_W-1:0]   rem_next;
        logic [QBITS-1:0]   quo_next;

        if (k == 0)
        begin : g_first
            assign v_in     = in_valid;
            assign rem_in   = REM_W'(in_data.d2);
            assign n2_in    = in_data.n2;
            assign quo_in   = '0;
            assign flags_in = in_data.flags;
        end
        else
        begin : g_rest
            assign v_in     = v_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign n2_in    = n2_reg[k-1];
            assign quo_in   = quo_reg[k-1];
            assign flags_in = flags_reg[k-1];
        end

        // trial subtract of the shifted divisor
        always_comb
        begin
            dvs      = REM_W'(n2_in) << (2 * SH + BIT);
            take     = rem_in >= dvs;
            rem_next = take ? rem_in - dvs : rem_in;
            quo_next = quo_in;
            quo_next[BIT] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]   <= rem_next;
                n2_reg[k]    <= n2_in;
                quo_reg[k]   <= quo_next;
                flags_reg[k] <= flags_in;
            end
        end
    end

    // top quotient bit set means the ratio reaches one
    assign out_valid      = v_reg[QBITS-1];
    assign out_data.flags = flags_reg[QBITS-1];
    assign out_data.sat   = quo_reg[QBITS-1][QBITS-1];
    assign out_data.ratio = quo_reg[QBITS-1][R_W-1:0];

endmodule

`default_nettype wire

[rtl/core/fcs_sqrt.sv]
// pipelined integer square root, one root bit per stage
// depends on fcs_pkg
`default_nettype none

module fcs_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire fcs_pkg::div_out_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output fcs_pkg::sqrt_out_t      out_data
);
    import fcs_pkg::*;

    localparam int NS = FRAC_BITS;

    logic             v_reg    [NS];
    logic             en       [NS];
    logic [R_W-1:0]   rem_reg  [NS];
    logic [R_W:0]     res_reg  [NS];
    logic             sat_reg  [NS];
    flags_t           flags_reg[NS];

    // stall chain
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int BIT = NS - 1 - k;
        logic             v_in;
        logic [R_W-1:0]   rem_in;
        logic [R_W:0]     res_in;
        logic             sat_in;
        flags_t           flags_in;
        logic [R_W:0]     one;
        logic [R_W:0]     trial;
        logic             take;
        logic [R_W-1:0]   rem_next;
        logic [R_W:0]     res_next;

        if (k == 0)
        begin : g_first
            assign v_in     = in_valid;
            assign rem_in   = in_data.ratio;
            assign res_in   = '0;
            assign sat_in   = in_data.sat;
            assign flags_in = in_data.flags;
        end
        else
        begin : g_rest
            assign v_in     = v_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign res_in   = res_reg[k-1];
            assign sat_in   = sat_reg[k-1];
            assign flags_in = flags_reg[k-1];
        end

        // digit-by-digit root step
        always_comb
        begin
            one      = (R_W + 1)'(1) << (2 * BIT);
            trial    = res_in + one;
            take     = {1'b0, rem_in} >= trial;
            rem_next = take ? rem_in - trial[R_W-1:0] : rem_in;
            res_next = (take ? res_in + (one << 1) : res_in) >> 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]   <= rem_next;
                res_reg[k]   <= res_next;
                sat_reg[k]   <= sat_in;
                flags_reg[k] <= flags_in;
            end
        end
    end

    assign out_valid      = v_reg[NS-1];
    assign out_data.flags = flags_reg[NS-1];
    assign out_data.sat   = sat_reg[NS-1];
    assign out_data.root  = res_reg[NS-1][FRAC_BITS-1:0];

endmodule

`default_nettype wire

[rtl/core/facet_cull_and_flat_shade.sv]
// facet back-face cull and flat lambert shade, top level
// depends on fcs_pkg, fcs_div, fcs_sqrt
// pipeline: 6 front stages, 31 divider stages, 15 root stages, 1 output stage
// throughput: one item per cycle when the output is not stalled; every stage holds its own valid bit and a stall
//   at the output only backs up into stages that hold an item
// reset clears all valid bits and loads the light registers with their defaults
`default_nettype none

module facet_cull_and_flat_shade (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest first), zero pad
    input  wire logic [fcs_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // visible, illumination, fill_colour, outline_colour (lowest first), zero pad
    output logic [fcs_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_addr,
    input  wire logic [fcs_pkg::LIGHT_BITS-1:0]  cfg_wdata
);
    import fcs_pkg::*;

    localparam int NF = 6;

    // light registers
    logic signed [LIGHT_BITS-1:0] light_x_reg, light_y_reg, light_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= LIGHT_X_RST;
            light_y_reg <= LIGHT_Y_RST;
            light_z_reg <= LIGHT_Z_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_LIGHT_X: light_x_reg <= cfg_wdata;
                CFG_LIGHT_Y: light_y_reg <= cfg_wdata;
                CFG_LIGHT_Z: light_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front pipeline control
    logic v_reg [NF];
    logic en    [NF];
    logic div_in_ready;

    always_comb
    begin
        en[NF-1] = !v_reg[NF-1] || div_in_ready;
        for (int k = NF - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NF; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NF; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: edge vectors about the pivot vertex
    logic signed [COORD_BITS-1:0] crd [NUM_COORDS];
    logic signed [DIFF_W-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_COORDS; i++)
        begin
            crd[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ux_reg <= DIFF_W'(crd[0]) - DIFF_W'(crd[3]);
            uy_reg <= DIFF_W'(crd[1]) - DIFF_W'(crd[4]);
            uz_reg <= DIFF_W'(crd[2]) - DIFF_W'(crd[5]);
            vx_reg <= DIFF_W'(crd[6]) - DIFF_W'(crd[3]);
            vy_reg <= DIFF_W'(crd[7]) - DIFF_W'(crd[4]);
            vz_reg <= DIFF_W'(crd[8]) - DIFF_W'(crd[5]);
        end
    end

    // stage 2: cross product
    logic signed [NRM_W-1:0] nx_reg, ny_reg, nz_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            nx_reg <= NRM_W'(uy_reg) * NRM_W'(vz_reg) - NRM_W'(uz_reg) * NRM_W'(vy_reg);
            ny_reg <= NRM_W'(uz_reg) * NRM_W'(vx_reg) - NRM_W'(ux_reg) * NRM_W'(vz_reg);
            nz_reg <= NRM_W'(ux_reg) * NRM_W'(vy_reg) - NRM_W'(uy_reg) * NRM_W'(vx_reg);
        end
    end

    // stage 3: light products and squared components
    logic signed [PROD_W-1:0]  px_reg, py_reg, pz_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg, sqz_reg;
    logic                      vis3_reg;
    logic signed [2*NRM_W-1:0] sqx_full, sqy_full, sqz_full;

    always_comb
    begin
        sqx_full = (2 * NRM_W)'(nx_reg) * (2 * NRM_W)'(nx_reg);
        sqy_full = (2 * NRM_W)'(ny_reg) * (2 * NRM_W)'(ny_reg);
        sqz_full = (2 * NRM_W)'(nz_reg) * (2 * NRM_W)'(nz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            px_reg   <= PROD_W'(nx_reg) * PROD_W'(light_x_reg);
            py_reg   <= PROD_W'(ny_reg) * PROD_W'(light_y_reg);
            pz_reg   <= PROD_W'(nz_reg) * PROD_W'(light_z_reg);
            sqx_reg  <= sqx_full[SQ_W-1:0];
            sqy_reg  <= sqy_full[SQ_W-1:0];
            sqz_reg  <= sqz_full[SQ_W-1:0];
            vis3_reg <= !nz_reg[NRM_W-1];
        end
    end

    // stage 4: dot product and squared length
    logic signed [DOT_W-1:0] dot;
    logic [N2_W-1:0]         n2_sum;
    logic [DOTU_W-1:0]       dotu_reg;
    logic [N2_W-1:0]         n24_reg;
    flags_t                  fl4_reg;

    always_comb
    begin
        dot    = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        n2_sum = N2_W'(sqx_reg) + N2_W'(sqy_reg) + N2_W'(sqz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            dotu_reg    <= dot[DOTU_W-1:0];
            n24_reg     <= n2_sum;
            fl4_reg.vis <= vis3_reg;
            fl4_reg.pos <= !dot[DOT_W-1] && (dot != '0) && (n2_sum != '0);
        end
    end

    // stage 5: partial products of the squared dot
    logic [2*DHI_W-1:0]       hh_reg;
    logic [DHI_W+DLO_W-1:0]   hl_reg;
    logic [2*DLO_W-1:0]       ll_reg;
    logic [N2_W-1:0]          n25_reg;
    flags_t                   fl5_reg;
    logic [DHI_W-1:0]         dhi;
    logic [DLO_W-1:0]         dlo;

    assign dhi = dotu_reg[DOTU_W-1:DLO_W];
    assign dlo = dotu_reg[DLO_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            hh_reg  <= (2 * DHI_W)'(dhi) * (2 * DHI_W)'(dhi);
            hl_reg  <= (DHI_W + DLO_W)'(dhi) * (DHI_W + DLO_W)'(dlo);
            ll_reg  <= (2 * DLO_W)'(dlo) * (2 * DLO_W)'(dlo);
            n25_reg <= n24_reg;
            fl5_reg <= fl4_reg;
        end
    end

    // stage 6: squared dot assembled
    div_in_t div_in_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            div_in_reg.d2    <= (D2_W'(hh_reg) << (2 * DLO_W))
                              + (D2_W'(hl_reg) << (DLO_W + 1))
                              + D2_W'(ll_reg);
            div_in_reg.n2    <= n25_reg;
            div_in_reg.flags <= fl5_reg;
        end
    end

    // ratio and root
    logic       div_out_valid, sqrt_in_ready;
    div_out_t   div_out;
    logic       sqrt_out_valid, out_en;
    sqrt_out_t  sqrt_out;

    fcs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[NF-1]),
        .in_ready  (div_in_ready),
        .in_data   (div_in_reg),
        .out_valid (div_out_valid),
        .out_ready (sqrt_in_ready),
        .out_data  (div_out)
    );

    fcs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_out_valid),
        .in_ready  (sqrt_in_ready),
        .in_data   (div_out),
        .out_valid (sqrt_out_valid),
        .out_ready (out_en),
        .out_data  (sqrt_out)
    );

    // output stage: clamp, palette indices
    logic [FRAC_BITS:0]   q;
    logic [FRAC_BITS+4:0] q14;
    logic [3:0]           fill;
    logic                 out_v_reg;
    logic                 vis_reg, outline_reg;
    logic [15:0]          illum_reg;
    logic [3:0]           fill_reg;

    assign out_en = !out_v_reg || m_tready;

    always_comb
    begin
        if (!sqrt_out.flags.pos)
        begin
            q = '0;
        end
        else if (sqrt_out.sat)
        begin
            q = (FRAC_BITS + 1)'(1) << FRAC_BITS;
        end
        else
        begin
            q = {1'b0, sqrt_out.root};
        end
        q14  = (FRAC_BITS + 5)'(q) * (FRAC_BITS + 5)'(FILL_STEPS);
        fill = 4'(q14 >> FRAC_BITS) + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_v_reg <= sqrt_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            vis_reg     <= sqrt_out.flags.vis;
            illum_reg   <= sqrt_out.flags.vis ? 16'(q) : '0;
            fill_reg    <= sqrt_out.flags.vis ? fill : '0;
            outline_reg <= sqrt_out.flags.vis && q[FRAC_BITS];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = M_TDATA_W'({outline_reg, fill_reg, illum_reg, vis_reg});

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking bench for facet_cull_and_flat_shade: cull flag and lambert shade per facet
// depends on fcs_pkg and the rtl top level; predicts each result and compares in order
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fcs_pkg::*;

    localparam int LATENCY   = 53;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1750;

    typedef struct {
        logic        visible;
        logic [15:0] illum;
        logic [3:0]  fill;
        logic        outline;
    } shade_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [LIGHT_BITS-1:0] cfg_wdata = '0;

    facet_cull_and_flat_shade dut (.*);

    always #5 clk = ~clk;

    // light direction as seen by the predictor
    logic signed [15:0] lx = LIGHT_X_RST, ly = LIGHT_Y_RST, lz = LIGHT_Z_RST;

    logic [S_TDATA_W-1:0] facet_q[$];
    shade_t shade_q[$];
    int send_idle = 31, recv_idle = 52;
    int errors = 0, n_seen = 0, n_vis = 0, n_full = 0, wdog = 0;
    bit hold_send = 1'b0;
    bit in_taken = 1'b0;

    // exact floor of 2^15 * dot/|n|, clamped to [0, 1.0]
    function automatic shade_t predict_shade(logic [S_TDATA_W-1:0] d);
        shade_t r;
        logic signed [63:0] c[9];
        logic signed [63:0] ux, uy, uz, vx, vy, vz, nx, ny, nz, dot;
        logic [127:0] n2, d2;
        logic [63:0] q, t;
        for (int i = 0; i < 9; i++)
            c[i] = 64'(signed'(d[i*12 +: 12]));
        ux = c[0] - c[3]; uy = c[1] - c[4]; uz = c[2] - c[5];
        vx = c[6] - c[3]; vy = c[7] - c[4]; vz = c[8] - c[5];
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        r = '{1'b0, 16'd0, 4'd0, 1'b0};
        if (nz < 0)
            return r;
        dot = nx * 64'(lx) + ny * 64'(ly) + nz * 64'(lz);
        n2 = 128'(nx * nx) + 128'(ny * ny) + 128'(nz * nz);
        q = 0;
        if (n2 != 0 && dot > 0) begin
            d2 = 128'(dot) * 128'(dot);
            if ((128'(1 << 30)) * n2 <= d2)
                q = 64'd32768;
            else
                for (int b = 14; b >= 0; b--) begin
                    t = q | (64'd1 << b);
                    if (128'(t * t) * n2 <= d2)
                        q = t;
                end
        end
        r.visible = 1'b1;
        r.illum   = q[15:0];
        r.fill    = 4'(((q * 14) >> 15) + 1);
        r.outline = (q >= 32768);
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_facet(int v[9]);
        logic [S_TDATA_W-1:0] d = '0;
        for (int i = 0; i < 9; i++)
            d[i*12 +: 12] = 12'(v[i]);
        return d;
    endfunction

    // driver: one item from the pending queue per handshake
    always @(negedge clk) begin
        if (rst_n) begin
            if (s_tvalid && !in_taken)
                ; // hold current item
            else if (facet_q.size() > 0 && !hold_send
                     && $urandom_range(99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= facet_q[0];
            end else
                s_tvalid <= 1'b0;
            in_taken = 1'b0;
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor: compare each result with the oldest prediction, record accepted inputs
    always @(posedge clk) begin
        shade_t e;
        if (rst_n) begin
            wdog <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0 : wdog + 1;
            if (m_tvalid && m_tready) begin
                n_seen <= n_seen + 1;
                if (shade_q.size() == 0) begin
                    $error("result with no prediction waiting");
                    errors++;
                end else begin
                    e = shade_q.pop_front();
                    if (e.visible) n_vis <= n_vis + 1;
                    if (e.outline) n_full <= n_full + 1;
                    if (m_tdata[0] !== e.visible) begin
                        $error("visible exp %0d got %0d", e.visible, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[16:1] !== e.illum) begin
                        $error("illumination exp %0d got %0d", e.illum, m_tdata[16:1]);
                        errors++;
                    end
                    if (m_tdata[20:17] !== e.fill) begin
                        $error("fill_colour exp %0d got %0d", e.fill, m_tdata[20:17]);
                        errors++;
                    end
                    if (m_tdata[21] !== e.outline) begin
                        $error("outline_colour exp %0d got %0d", e.outline, m_tdata[21]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                shade_q.push_back(predict_shade(s_tdata));
                void'(facet_q.pop_front());
                in_taken = 1'b1;
            end
            if (wdog >= WDOG_MAX) begin
                $display("watchdog: no progress for %0d cycles", WDOG_MAX);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (facet_q.size() > 0 || s_tvalid || shade_q.size() > 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_light(cfg_idx_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LIGHT_X: lx = val;
            CFG_LIGHT_Y: ly = val;
            default:     lz = val;
        endcase
    endtask

    task automatic set_light(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        write_light(CFG_LIGHT_X, x);
        write_light(CFG_LIGHT_Y, y);
        write_light(CFG_LIGHT_Z, z);
    endtask

    // random coordinate, mostly mid range, sometimes the extremes
    function automatic int rand_coord(int span);
        case ($urandom_range(9))
            0: return -2048;
            1: return 2047;
            2: return $urandom_range(4095) - 2048;
            default: return $urandom_range(2 * span) - span;
        endcase
    endfunction

    task automatic queue_random(int n);
        int v[9];
        int span;
        for (int k = 0; k < n; k++) begin
            span = ($urandom_range(3) == 0) ? 2047 : $urandom_range(64, 1);
            for (int i = 0; i < 9; i++)
                v[i] = rand_coord(span);
            // occasional degenerate or collinear facet
            if ($urandom_range(19) == 0)
                for (int i = 0; i < 3; i++)
                    v[6 + i] = v[i];
            facet_q.push_back(pack_facet(v));
        end
    endtask

    initial begin
        int v[9];
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: degenerate, both windings, axis aligned, extremes
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                        facet_q.push_back(pack_facet(v));
        v = '{1, 0, 0, 0, 0, 0, 0, 1, 0};                        facet_q.push_back(pack_facet(v));
        v = '{0, 1, 0, 0, 0, 0, 1, 0, 0};                        facet_q.push_back(pack_facet(v));
        v = '{0, 0, 1, 0, 0, 0, 1, 0, 0};                        facet_q.push_back(pack_facet(v));
        v = '{0, 1, 0, 0, 0, 0, 0, 0, 1};                        facet_q.push_back(pack_facet(v));
        v = '{2047, -2048, 2047, -2048, 2047, -2048, -2048, -2048, 2047};
        facet_q.push_back(pack_facet(v));
        v = '{-2048, 2047, -2048, 2047, -2048, 2047, 2047, 2047, -2048};
        facet_q.push_back(pack_facet(v));
        v = '{2047, -2048, 0, -2048, -2048, 0, -2048, 2047, 0};  facet_q.push_back(pack_facet(v));
        v = '{-2048, -2048, -2048, 2047, 2047, 2047, -2048, -2048, -2048};
        facet_q.push_back(pack_facet(v));
        v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};               facet_q.push_back(pack_facet(v));
        wait_drained();

        // light straight along z, then along (-1, -1, -1), then over-unit
        set_light(16'd0, 16'd0, 16'h7fff);
        v = '{1, 0, 0, 0, 0, 0, 0, 1, 0};                        facet_q.push_back(pack_facet(v));
        v = '{0, 0, 1, 0, 0, 0, 1, 0, 0};                        facet_q.push_back(pack_facet(v));
        wait_drained();
        set_light(16'h8000, 16'h8000, 16'h8000);
        v = '{1, 0, 0, 0, 0, 0, 0, 1, 0};                        facet_q.push_back(pack_facet(v));
        v = '{0, 1, 0, 0, 0, 0, 0, 0, 1};                        facet_q.push_back(pack_facet(v));
        wait_drained();
        set_light(16'h7fff, 16'h7fff, 16'h7fff);
        v = '{1, 0, 0, 0, 0, 0, 0, 1, 0};                        facet_q.push_back(pack_facet(v));
        v = '{0, 1, 0, 0, 0, 0, 1, 0, 0};                        facet_q.push_back(pack_facet(v));
        wait_drained();

        // random phase one: reset light, sender idles less than receiver
        set_light(LIGHT_X_RST, LIGHT_Y_RST, LIGHT_Z_RST);
        queue_random(N_RANDOM / 3);
        wait_drained();

        // phase two: roles swapped, random light
        send_idle = 52; recv_idle = 31;
        set_light(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)));
        queue_random(N_RANDOM / 3);
        // partway through, sender holds off until everything in flight is out
        while (facet_q.size() > N_RANDOM / 6) @(negedge clk);
        hold_send = 1'b1;
        while (shade_q.size() > 0 || s_tvalid) @(negedge clk);
        hold_send = 1'b0;
        wait_drained();

        // phase three: no idling, light (0.6, -0.8, 0)
        send_idle = 0; recv_idle = 0;
        set_light(16'd19661, -16'sd26214, 16'd0);
        queue_random(N_RANDOM / 3);
        queue_random(N_RANDOM / 3 > 0 ? 1 : 0);
        wait_drained();

        $display("covered %0d facets, %0d visible, %0d at full intensity, over six light settings",
                 n_seen, n_vis, n_full);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
